// ----- hw/rtl/alpha_over_pixel_blend_assert.svh -----
// Assertion macros for the alpha-over blend divider RTL.
`ifndef ALPHA_OVER_PIXEL_BLEND_ASSERT_SVH
`define ALPHA_OVER_PIXEL_BLEND_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define APB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apb assertion failed");

// Next-cycle implication, checked out of reset.
`define APB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apb assertion failed");

`endif

// ----- hw/rtl/apb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the alpha-over blend.
`default_nettype none
package apb_pkg;

  localparam int unsigned NUM_CHAN = 3;

  // Configuration register indexes.
  localparam logic REG_FORMAT   = 1'b0;
  localparam logic REG_MODULATE = 1'b1;

  localparam logic [7:0] BYTE_MAX = 8'hFF;

  // Request passed from the front pipeline to the divider pipeline.
  typedef struct packed {
    logic [31:0]                 ground;
    logic [31:0]                 top;
    logic [7:0]                  aout;
    logic [NUM_CHAN-1:0][15:0]   sp;
    logic [NUM_CHAN-1:0][23:0]   dd;
    logic                        pass_ground;
    logic                        pass_top;
  } apb_mid_t;

  // Exact floor(x / 255) for x up to 65279, by reciprocal 32897 / 2^23.
  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [31:0] prod;
    prod = ({16'd0, x} << 15) + ({16'd0, x} << 7) + {16'd0, x};
    return prod[30:23];
  endfunction

  // Exact floor(x / 255) for x up to 255^3, by reciprocal 0x01010102 / 2^32.
  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [48:0] prod;
    prod = ({25'd0, x} << 24) + ({25'd0, x} << 16) + ({25'd0, x} << 8)
         + ({25'd0, x} << 1);
    return prod[47:32];
  endfunction

  // Alpha sits in the low byte for the RGBA and BGRA orders.
  function automatic logic alpha_low(input logic [1:0] fmt);
    return fmt[1];
  endfunction

  // Byte position of colour channel c.
  function automatic logic [1:0] chan_pos(input logic low, input logic [1:0] c);
    return low ? 2'(c + 2'd1) : c;
  endfunction

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
    return w[{idx, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/alpha_over_pixel_blend.sv -----
// Top level of the straight-alpha over compositor with configuration registers.
`default_nettype none
// One pixel request enters per clock while nothing stalls, and its result passes
// four front stages (colour modulation, source alpha,
// the alpha and colour products, output alpha) and three divider stages
// (numerators, four restoring division steps, then the last four steps with the
// output register).
// A stall on the output backs up stage by stage, so empty stages still fill.
// Configuration must only be written while no request is in flight.
module alpha_over_pixel_blend (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_ground_pixel,
  input  wire logic [31:0] in_top_pixel,
  input  wire logic [7:0]  in_intensity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_blended_pixel
);

  logic [1:0]  fmt_r;
  logic [31:0] mod_r;
  logic        in_ready, mid_valid, mid_ready;
  apb_pkg::apb_mid_t mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 2'd0;
      mod_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apb_pkg::REG_FORMAT:   fmt_r <= cfg_data[1:0];
        apb_pkg::REG_MODULATE: mod_r <= cfg_data;
        default: ;
      endcase
    end
  end

  apb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .modulate  (mod_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ground    (in_ground_pixel),
    .top       (in_top_pixel),
    .intensity (in_intensity),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  apb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .result    (out_blended_pixel)
  );

  assign in_stall = !in_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/apb_front.sv -----
// Front pipeline: modulation, source alpha, products and output alpha (four stages).
`default_nettype none
module apb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         fmt,
  input  wire logic [31:0]        modulate,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        ground,
  input  wire logic [31:0]        top,
  input  wire logic [7:0]         intensity,
  output logic                    mid_valid,
  input  wire logic               mid_ready,
  output apb_pkg::apb_mid_t       mid
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [31:0] g1_r, t1_r;
  logic [7:0]  int1_r;
  logic [31:0] t1_nxt;

  logic [31:0] g2_r, t2_r;
  logic [7:0]  as2_r, ad2_r;
  logic [7:0]  as2_nxt;

  logic [31:0] g3_r, t3_r;
  logic [7:0]  as3_r;
  logic [15:0] p3_r;
  logic [apb_pkg::NUM_CHAN-1:0][15:0] sp3_r, sp3_nxt;
  logic        pg3_r, pt3_r;

  logic [8:0]  asum;
  logic [7:0]  aout_nxt;
  logic [apb_pkg::NUM_CHAN-1:0][23:0] dd_nxt;
  apb_pkg::apb_mid_t mid_r;

  assign rdy4     = !v4_r || mid_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      t1_nxt[b*8 +: 8] = apb_pkg::div255_16({8'd0, top[b*8 +: 8]} *
                                            {8'd0, modulate[b*8 +: 8]});
    end
  end

  always_comb begin
    as2_nxt = apb_pkg::div255_16(
      {8'd0, apb_pkg::byte_of(t1_r, apb_pkg::alpha_low(fmt) ? 2'd0 : 2'd3)} *
      {8'd0, int1_r});
  end

  always_comb begin
    for (int c = 0; c < apb_pkg::NUM_CHAN; c++) begin
      sp3_nxt[c] = {8'd0, apb_pkg::byte_of(t2_r,
        apb_pkg::chan_pos(apb_pkg::alpha_low(fmt), 2'(c)))} * {8'd0, as2_r};
    end
  end

  always_comb begin
    asum     = {1'b0, as3_r} + {1'b0, apb_pkg::div255_16(p3_r)};
    aout_nxt = asum[8] ? apb_pkg::BYTE_MAX : asum[7:0];
    for (int c = 0; c < apb_pkg::NUM_CHAN; c++) begin
      dd_nxt[c] = {16'd0, apb_pkg::byte_of(g3_r,
        apb_pkg::chan_pos(apb_pkg::alpha_low(fmt), 2'(c)))} * {8'd0, p3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      g1_r   <= ground;
      t1_r   <= t1_nxt;
      int1_r <= intensity;
    end
    if (rdy2) begin
      g2_r  <= g1_r;
      t2_r  <= t1_r;
      as2_r <= as2_nxt;
      ad2_r <= apb_pkg::byte_of(g1_r, apb_pkg::alpha_low(fmt) ? 2'd0 : 2'd3);
    end
    if (rdy3) begin
      g3_r  <= g2_r;
      t3_r  <= t2_r;
      as3_r <= as2_r;
      p3_r  <= {8'd0, ad2_r} * {8'd0, apb_pkg::BYTE_MAX - as2_r};
      sp3_r <= sp3_nxt;
      pg3_r <= (as2_r == 8'd0);
      pt3_r <= (as2_r == apb_pkg::BYTE_MAX) && (ad2_r == apb_pkg::BYTE_MAX);
    end
    if (rdy4) begin
      mid_r.ground      <= g3_r;
      mid_r.top         <= t3_r;
      mid_r.aout        <= aout_nxt;
      mid_r.sp          <= sp3_r;
      mid_r.dd          <= dd_nxt;
      mid_r.pass_ground <= pg3_r || (aout_nxt == 8'd0);
      mid_r.pass_top    <= pt3_r;
    end
  end

  assign mid_valid = v4_r;
  assign mid       = mid_r;

endmodule
`default_nettype wire

// ----- hw/rtl/apb_div.sv -----
// Divider pipeline: numerators, division by output alpha and result assembly.
`default_nettype none
`include "alpha_over_pixel_blend_assert.svh"
module apb_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         fmt,
  input  wire logic               mid_valid,
  output logic                    mid_ready,
  input  apb_pkg::apb_mid_t       mid,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             result
);

  localparam int unsigned NC = apb_pkg::NUM_CHAN;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [31:0] g1_r, t1_r, g2_r, t2_r;
  logic [7:0]  a1_r, a2_r;
  logic        pg1_r, pt1_r, pg2_r, pt2_r;
  logic [NC-1:0]       ovf1_r, ovf2_r;
  logic [NC-1:0][7:0]  rem1_r, rem2_r, lo1_r, lo2_r;
  logic [NC-1:0][3:0]  qh2_r;

  logic [NC-1:0][16:0] num;
  logic [NC-1:0]       ovf_nxt;
  logic [NC-1:0][7:0]  rem2_nxt;
  logic [NC-1:0][3:0]  qh_nxt;
  logic [NC-1:0][3:0]  ql_nxt;
  logic [8:0]          r9a, r9b;
  logic [7:0]          ra, rb;
  logic [31:0]         res_nxt;
  logic [31:0]         res_r;

  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign mid_ready = rdy1;

  // A quotient above 255 exists exactly when the top bits already reach aout.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      num[c]     = 17'(mid.sp[c]) + 17'(apb_pkg::div255_24(mid.dd[c]));
      ovf_nxt[c] = (num[c][16:8] >= {1'b0, mid.aout});
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      ra = rem1_r[c];
      for (int k = 7; k >= 4; k--) begin
        r9a = {ra, lo1_r[c][k]};
        if (r9a >= {1'b0, a1_r}) begin
          r9a = r9a - {1'b0, a1_r};
          qh_nxt[c][k-4] = 1'b1;
        end else begin
          qh_nxt[c][k-4] = 1'b0;
        end
        ra = r9a[7:0];
      end
      rem2_nxt[c] = ra;
    end
  end

  always_comb begin
    res_nxt = 32'd0;
    for (int c = 0; c < NC; c++) begin
      rb = rem2_r[c];
      for (int k = 3; k >= 0; k--) begin
        r9b = {rb, lo2_r[c][k]};
        if (r9b >= {1'b0, a2_r}) begin
          r9b = r9b - {1'b0, a2_r};
          ql_nxt[c][k] = 1'b1;
        end else begin
          ql_nxt[c][k] = 1'b0;
        end
        rb = r9b[7:0];
      end
    end
    priority if (pg2_r) begin
      res_nxt = g2_r;
    end else if (pt2_r) begin
      res_nxt = t2_r;
    end else begin
      res_nxt[(apb_pkg::alpha_low(fmt) ? 0 : 24) +: 8] = a2_r;
      for (int c = 0; c < NC; c++) begin
        res_nxt[{apb_pkg::chan_pos(apb_pkg::alpha_low(fmt), 2'(c)), 3'b000} +: 8] =
          ovf2_r[c] ? apb_pkg::BYTE_MAX : {qh2_r[c], ql_nxt[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= mid_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      g1_r  <= mid.ground;
      t1_r  <= mid.top;
      a1_r  <= mid.aout;
      pg1_r <= mid.pass_ground;
      pt1_r <= mid.pass_top;
      ovf1_r <= ovf_nxt;
      for (int c = 0; c < NC; c++) begin
        rem1_r[c] <= num[c][15:8];
        lo1_r[c]  <= num[c][7:0];
      end
    end
    if (rdy2) begin
      g2_r   <= g1_r;
      t2_r   <= t1_r;
      a2_r   <= a1_r;
      pg2_r  <= pg1_r;
      pt2_r  <= pt1_r;
      ovf2_r <= ovf1_r;
      rem2_r <= rem2_nxt;
      lo2_r  <= lo1_r;
      qh2_r  <= qh_nxt;
    end
    if (rdy3) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign result    = res_r;

  // A request that is blended always has a nonzero output alpha.
  `APB_ASSERT_IMP(a_aout_nonzero, v1_r && !pg1_r, a1_r != 8'd0)
  // The partial remainder of channel 0, when it does not saturate, stays below the divisor.
  `APB_ASSERT_IMP(a_rem_bound, v2_r && !pg2_r && !ovf2_r[0], rem2_r[0] < a2_r)
  // A request held back by the output stage is not dropped.
  `APB_ASSERT_NXT(a_no_drop, v2_r && !rdy3, v2_r)

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the straight-alpha over pixel compositor.
`default_nettype none
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_ground_pixel = '0;
  logic [31:0] in_top_pixel = '0;
  logic [7:0]  in_intensity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_blended_pixel;

  alpha_over_pixel_blend uut (.*);

  always #5 clk = ~clk;

  // Predictor copy of the configuration registers.
  logic [1:0]  fmt_q = 2'd0;
  logic [31:0] mod_q = 32'hFFFF_FFFF;
  logic [31:0] pixel_q[$];
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  bit          stall_busy = 1'b0;

  function automatic logic [31:0] blend_pixel(logic [31:0] g, logic [31:0] tp,
                                              logic [7:0] inten);
    logic [31:0] t, res;
    int unsigned ash, as_, ad, inv, aout, s, d, c;
    t = '0;
    for (int sh = 0; sh < 32; sh += 8)
      t[sh +: 8] = 8'((int'(tp[sh +: 8]) * int'(mod_q[sh +: 8])) / 255);
    ash = fmt_q[1] ? 0 : 24;
    as_ = (t[ash +: 8] * inten) / 255;
    if (as_ == 0) return g;
    ad = g[ash +: 8];
    if (as_ == 255 && ad == 255) return t;
    inv = 255 - as_;
    aout = as_ + (ad * inv) / 255;
    if (aout > 255) aout = 255;
    if (aout == 0) return g;
    res = '0;
    res[ash +: 8] = 8'(aout);
    for (int sh = 0; sh < 32; sh += 8) begin
      if (sh == ash) continue;
      s = t[sh +: 8];
      d = g[sh +: 8];
      c = (s * as_ + (d * ad * inv) / 255) / aout;
      if (c > 255) c = 255;
      res[sh +: 8] = 8'(c);
    end
    return res;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // Leaves the valid high; the caller lowers it when a gap follows.
  task automatic send_pixel(logic [31:0] g, logic [31:0] tp, logic [7:0] inten);
    in_valid <= 1'b1;
    in_ground_pixel <= g;
    in_top_pixel <= tp;
    in_intensity <= inten;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(blend_pixel(g, tp, inten));
    @(negedge clk);
  endtask

  task automatic send_gapped(logic [31:0] g, logic [31:0] tp, logic [7:0] inten);
    int gap;
    send_pixel(g, tp, inten);
    gap = stall_busy ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Registers are only written with the pipeline empty.
  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == apb_pkg::REG_FORMAT) fmt_q = val[1:0];
    else mod_q = val;
  endtask

  // Result checker and idle watchdog; the receiver-side stalls follow below.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0)
          report_mismatch("unexpected request", out_blended_pixel, 'x);
        else if (out_blended_pixel !== pixel_q[0])
          report_mismatch("blended_pixel", out_blended_pixel, pixel_q.pop_front());
        else
          void'(pixel_q.pop_front());
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!stall_busy && $urandom_range(0, 5) == 0) begin
        n = gap_len() + 1;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    logic [31:0] px[6] = '{32'h0, 32'hFFFF_FFFF, 32'hFF00_00FF, 32'h80FF_0080,
                           32'h01FE_7F80, 32'hFF12_34FF};
    for (int f = 0; f < 4; f++) begin
      write_reg(apb_pkg::REG_FORMAT, 32'(f));
      send_gapped(32'h1234_5678, 32'h00AB_CD00, 8'hFF);      // transparent source
      send_gapped(32'hFF10_20FF, 32'hFFA0_B0FF, 8'hFF);      // both opaque
      send_gapped(32'h0000_0000, 32'hFFFF_FFFF, 8'h00);      // zero intensity
      send_gapped(32'h00FF_FF00, 32'h01FF_FF01, 8'h01);      // source alpha rounds to zero
      send_gapped(px[f], px[5 - f], 8'h80);
    end
    drain();
  endtask

  task automatic test_random(int count);
    logic [31:0] g, tp;
    for (int i = 0; i < count; i++) begin
      g = $urandom();
      tp = $urandom();
      // Bias alpha bytes towards the opaque and transparent corners.
      if ($urandom_range(0, 3) == 0) begin g[31:24] = 8'hFF; g[7:0] = 8'hFF; end
      if ($urandom_range(0, 5) == 0) begin tp[31:24] = 8'hFF; tp[7:0] = 8'hFF; end
      if ($urandom_range(0, 7) == 0) begin g[31:24] = 8'h00; g[7:0] = 8'h00; end
      send_gapped(g, tp, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom()));
    end
    drain();
  endtask

  task automatic test_config_sweep();
    logic [31:0] mods[4] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_FF80, 32'h0};
    for (int k = 0; k < 8; k++) begin
      write_reg(apb_pkg::REG_FORMAT, 32'($urandom_range(0, 3)));
      write_reg(apb_pkg::REG_MODULATE, (k < 3) ? mods[k] : $urandom());
      test_random(150);
    end
  endtask

  task automatic test_back_to_back();
    stall_busy = 1'b1;
    write_reg(apb_pkg::REG_FORMAT, 32'd3);
    write_reg(apb_pkg::REG_MODULATE, 32'hFFFF_FFFF);
    test_random(200);
    stall_busy = 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(300);
    test_config_sweep();
    test_back_to_back();
    if (err_count == 0 && pixel_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/apb_pkg.sv
hw/rtl/apb_front.sv
hw/rtl/apb_div.sv
hw/rtl/alpha_over_pixel_blend.sv
sim/testbench.sv
